// ===== rtl/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg - shared types and constants for the LIFO stack with dump
// Command and status codes, reset values and the controller/datapath
// interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_VIEW = 2'd2,
    CMD_NONE = 2'd3
  } cmd_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } stat_code_t;

  // controller -> datapath
  typedef struct packed {
    logic push_ok;     // write word, bump count, answer ok
    logic push_ovf;    // answer overflow
    logic underflow;   // answer underflow
    logic pop_start;   // drop count, read the popped top entry
    logic view_start;  // clear walk index, enter view mode
    logic rd_issue;    // read entry at walk index
    logic emit;        // load output with read data
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic last_item;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lifo_stack_with_dump_top.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_dump_top - bounded LIFO stack of signed words with dump
// Push, pop and view (dump all entries bottom to top) on a stack of up to
// DEPTH 32-bit words, with an APB-style capacity register.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | in_cmd, in_push_value
//  out_    | output    | out_valid/out_stall| out_status, out_data_word,
//          |           |                    | out_position, out_last
//  cfg_    | input     | APB psel/penable   | cfg_paddr, cfg_pwdata/prdata
//
//  Push, overflow and underflow answers appear in the cycle after the
//  transaction. A pop reads the top entry and then emits it; a view starts,
//  then reads and emits each stored entry in turn. Both are paced by the
//  single registered read port of the stack RAM.
//  The input is stalled while a pop or view is in progress and while a
//  result waits in a stalled output register. Synchronous active-low reset
//  empties the stack and sets capacity to 64; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_dump_top #(
  parameter int DEPTH = lsd_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input transactions
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lsd_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic signed [lsd_pkg::WORD_W-1:0] in_push_value,
  // result transactions
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [lsd_pkg::STAT_W-1:0]  out_status,
  output logic signed [lsd_pkg::WORD_W-1:0] out_data_word,
  output logic      [lsd_pkg::POS_W-1:0]   out_position,
  output logic                             out_last,
  // configuration
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [2:0]                  cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);

  lsd_pkg::ctl_cmd_t ctl_cmd;
  lsd_pkg::ctl_sts_t ctl_sts;

  logic [lsd_pkg::CAP_W-1:0] capacity_r, capacity_nxt;
  logic                      cfg_sel_cap;
  logic [lsd_pkg::WORD_W-1:0] dp_word;

  // Word address lives in paddr[2]; only the capacity register exists.
  assign cfg_sel_cap = (cfg_paddr[2] == lsd_pkg::REG_CAPACITY);
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = cfg_sel_cap ? 32'(capacity_r) : 32'd0;

  always_comb begin
    capacity_nxt = capacity_r;
    // commit the write in the access phase
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_cap) begin
      capacity_nxt = cfg_pwdata[lsd_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lsd_pkg::CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // Sequencer: decode commands, hold off input during pop and view walks.
  lsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // Storage, count and output register.
  lsd_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (ctl_cmd),
    .sts           (ctl_sts),
    .capacity      (capacity_r),
    .push_value    (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_data_word (dp_word),
    .out_position  (out_position),
    .out_last      (out_last)
  );

  assign out_data_word = dp_word;

`ifndef ASSERT_OFF
  a_cap_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_cap)
      |=> capacity_r == $past(cfg_pwdata[lsd_pkg::CAP_W-1:0]))
    else $error("capacity write lost");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != lsd_pkg::ST_RSVD))
    else $error("reserved status on output");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != lsd_pkg::ST_OK)) |-> (out_data_word == '0) && out_last)
    else $error("error result carries data or is not final");
`endif

endmodule

`default_nettype wire

// ===== rtl/lsd_ram.sv =====
// ----------------------------------------------------------------------------
// lsd_ram - generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/lsd_datapath.sv =====
// ----------------------------------------------------------------------------
// lsd_datapath - stack storage, entry count, walk index and output register
// Executes controller commands and reports stack and output status.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_datapath #(
  parameter int DEPTH = lsd_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lsd_pkg::ctl_cmd_t             cmd,
  output lsd_pkg::ctl_sts_t                  sts,
  input  wire logic [lsd_pkg::CAP_W-1:0]     capacity,
  input  wire logic [lsd_pkg::WORD_W-1:0]    push_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [lsd_pkg::STAT_W-1:0]    out_status,
  output logic      [lsd_pkg::WORD_W-1:0]    out_data_word,
  output logic      [lsd_pkg::POS_W-1:0]     out_position,
  output logic                               out_last
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [CNTW-1:0] count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            view_r, view_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [lsd_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [lsd_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [lsd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic            last_r, last_nxt;

  logic [CNTW-1:0] count_dec;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [lsd_pkg::WORD_W-1:0] ram_rdata;

  assign count_dec = count_r - CNTW'(1);
  assign ram_re    = cmd.pop_start | cmd.rd_issue;
  assign ram_raddr = cmd.pop_start ? count_dec[AW-1:0] : idx_r;

  lsd_ram #(
    .WIDTH (lsd_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push_ok),
    .waddr (count_r[AW-1:0]),
    .wdata (push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.empty     = (count_r == '0);
    sts.full      = (8'(count_r) >= 8'(capacity)) || (32'(count_r) >= DEPTH);
    sts.out_free  = !out_valid_r || !out_stall;
    sts.last_item = !view_r || ((CNTW'(idx_r) + CNTW'(1)) == count_r);
  end

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    view_nxt      = view_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    word_nxt      = word_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    if (cmd.push_ok || cmd.push_ovf || cmd.underflow) begin
      out_valid_nxt = 1'b1;
      word_nxt      = '0;
      pos_nxt       = '0;
      last_nxt      = 1'b1;
      if (cmd.push_ok) begin
        status_nxt = lsd_pkg::ST_OK;
        count_nxt  = count_r + CNTW'(1);
      end else if (cmd.push_ovf) begin
        status_nxt = lsd_pkg::ST_OVERFLOW;
      end else begin
        status_nxt = lsd_pkg::ST_UNDERFLOW;
      end
    end
    if (cmd.pop_start) begin
      count_nxt = count_dec;
      idx_nxt   = '0;
      view_nxt  = 1'b0;
    end
    if (cmd.view_start) begin
      idx_nxt  = '0;
      view_nxt = 1'b1;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      status_nxt    = lsd_pkg::ST_OK;
      word_nxt      = ram_rdata;
      pos_nxt       = view_r ? lsd_pkg::POS_W'(idx_r) : '0;
      last_nxt      = sts.last_item;
      idx_nxt       = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      view_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      view_r      <= view_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    word_r   <= word_nxt;
    pos_r    <= pos_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data_word = word_r;
  assign out_position  = pos_r;
  assign out_last      = last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("entry count above depth");

  a_push_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_ok |=> count_r == $past(count_r) + CNTW'(1))
    else $error("push did not advance entry count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_start || cmd.view_start || cmd.rd_issue) |-> !sts.empty)
    else $error("stack read while empty");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.push_ok || cmd.push_ovf || cmd.underflow) |-> sts.out_free)
    else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/lsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsd_ctrl - command sequencer for the LIFO stack
// Decodes input transactions and steps pops and view walks through the
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lsd_pkg::CMD_W-1:0]    in_cmd,
  input  wire lsd_pkg::ctl_sts_t            sts,
  output lsd_pkg::ctl_cmd_t                 cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          case (lsd_pkg::cmd_code_t'(in_cmd))
            lsd_pkg::CMD_PUSH: begin
              cmd.push_ok  = !sts.full;
              cmd.push_ovf = sts.full;
            end
            lsd_pkg::CMD_POP: begin
              if (sts.empty) begin
                cmd.underflow = 1'b1;
              end else begin
                cmd.pop_start = 1'b1;
                state_nxt     = S_EMIT;
              end
            end
            lsd_pkg::CMD_VIEW: begin
              if (sts.empty) begin
                cmd.underflow = 1'b1;
              end else begin
                cmd.view_start = 1'b1;
                state_nxt      = S_READ;
              end
            end
            default: begin
              // unused code: drop the transaction
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_item ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while a command is in progress");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_item) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after final result");

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_EMIT))
    else $error("read not followed by emit");
`endif

endmodule

`default_nettype wire
